@@ design/u2g_pkg.sv @@
// shared types, constants and code point lookup for the utf-8 to glyph converter
package u2g_pkg;

  localparam int CP_W       = 21;
  localparam int SLOTS      = 240;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);
  localparam logic [7:0] FIRST_GLYPH = 8'h10;
  localparam logic [CP_W-1:0] ASCII_LIMIT = 21'h00080;

  typedef logic [CP_W-1:0] cp_t;

  typedef struct packed {
    logic valid;
    cp_t  cp;
  } cp_item_t;

  typedef struct packed {
    logic hit;
    logic [7:0] glyph;
  } lookup_t;

  localparam cp_t CP_OF_SLOT [SLOTS] = '{
    21'h025ae, 21'h025a0, 21'h025a1, 21'h02059, 21'h02058, 21'h02016, 21'h025c0, 21'h025b6,
    21'h0300c, 21'h0300d, 21'h000a5, 21'h02022, 21'h03001, 21'h03002, 21'h0309b, 21'h0309c,
    21'h00020, 21'h00021, 21'h00022, 21'h00023, 21'h00024, 21'h00025, 21'h00026, 21'h00027,
    21'h00028, 21'h00029, 21'h0002a, 21'h0002b, 21'h0002c, 21'h0002d, 21'h0002e, 21'h0002f,
    21'h00030, 21'h00031, 21'h00032, 21'h00033, 21'h00034, 21'h00035, 21'h00036, 21'h00037,
    21'h00038, 21'h00039, 21'h0003a, 21'h0003b, 21'h0003c, 21'h0003d, 21'h0003e, 21'h0003f,
    21'h00040, 21'h1d622, 21'h1d623, 21'h1d624, 21'h1d625, 21'h1d626, 21'h1d627, 21'h1d628,
    21'h1d629, 21'h1d62a, 21'h1d62b, 21'h1d62c, 21'h1d62d, 21'h1d62e, 21'h1d62f, 21'h1d630,
    21'h1d631, 21'h1d632, 21'h1d633, 21'h1d634, 21'h1d635, 21'h1d636, 21'h1d637, 21'h1d638,
    21'h1d639, 21'h1d63a, 21'h1d63b, 21'h0005b, 21'h0005c, 21'h0005d, 21'h0005e, 21'h0005f,
    21'h00060, 21'h00061, 21'h00062, 21'h00063, 21'h00064, 21'h00065, 21'h00066, 21'h00067,
    21'h00068, 21'h00069, 21'h0006a, 21'h0006b, 21'h0006c, 21'h0006d, 21'h0006e, 21'h0006f,
    21'h00070, 21'h00071, 21'h00072, 21'h00073, 21'h00074, 21'h00075, 21'h00076, 21'h00077,
    21'h00078, 21'h00079, 21'h0007a, 21'h0007b, 21'h0007c, 21'h0007d, 21'h0007e, 21'h025cb,
    21'h02588, 21'h02592, 21'h1f431, 21'h02b07, 21'h02591, 21'h0273d, 21'h025cf, 21'h02665,
    21'h02609, 21'h0c6c3, 21'h02302, 21'h02b05, 21'h1f610, 21'h0266a, 21'h1f17e, 21'h025c6,
    21'h02026, 21'h027a1, 21'h02605, 21'h029d7, 21'h02b06, 21'h002c7, 21'h02227, 21'h0274e,
    21'h025a4, 21'h025a5, 21'h03042, 21'h03044, 21'h03046, 21'h03048, 21'h0304a, 21'h0304b,
    21'h0304d, 21'h0304f, 21'h03051, 21'h03053, 21'h03055, 21'h03057, 21'h03059, 21'h0305b,
    21'h0305d, 21'h0305f, 21'h03061, 21'h03064, 21'h03066, 21'h03068, 21'h0306a, 21'h0306b,
    21'h0306c, 21'h0306d, 21'h0306e, 21'h0306f, 21'h03072, 21'h03075, 21'h03078, 21'h0307b,
    21'h0307e, 21'h0307f, 21'h03080, 21'h03081, 21'h03082, 21'h03084, 21'h03086, 21'h03088,
    21'h03089, 21'h0308a, 21'h0308b, 21'h0308c, 21'h0308d, 21'h0308f, 21'h03092, 21'h03093,
    21'h03063, 21'h03083, 21'h03085, 21'h03087, 21'h030a2, 21'h030a4, 21'h030a6, 21'h030a8,
    21'h030aa, 21'h030ab, 21'h030ad, 21'h030af, 21'h030b1, 21'h030b3, 21'h030b5, 21'h030b7,
    21'h030b9, 21'h030bb, 21'h030bd, 21'h030bf, 21'h030c1, 21'h030c4, 21'h030c6, 21'h030c8,
    21'h030ca, 21'h030cb, 21'h030cc, 21'h030cd, 21'h030ce, 21'h030cf, 21'h030d2, 21'h030d5,
    21'h030d8, 21'h030db, 21'h030de, 21'h030df, 21'h030e0, 21'h030e1, 21'h030e2, 21'h030e4,
    21'h030e6, 21'h030e8, 21'h030e9, 21'h030ea, 21'h030eb, 21'h030ec, 21'h030ed, 21'h030ef,
    21'h030f2, 21'h030f3, 21'h030c3, 21'h030e3, 21'h030e5, 21'h030e7, 21'h025dc, 21'h025dd
  };

  // ascii passes through, anything else is matched against the slot table
  function automatic lookup_t glyph_lookup(cp_t cp);
    lookup_t res;
    res.hit   = 1'b0;
    res.glyph = '0;
    if (cp < ASCII_LIMIT) begin
      res.hit   = 1'b1;
      res.glyph = cp[7:0];
    end else begin
      for (int i = 0; i < SLOTS; i++) begin
        if (cp == CP_OF_SLOT[i]) begin
          res.hit   = 1'b1;
          res.glyph = FIRST_GLYPH + 8'(i);
        end
      end
    end
    return res;
  endfunction

endpackage

@@ design/u2g_front.sv @@
// byte decoder and code point queue
module u2g_front import u2g_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  logic [7:0] text_byte,
  input  logic     end_of_text,
  output logic     full,
  output cp_item_t head,
  input  logic     take
);

  cp_t              part_r, part_nxt;
  logic [1:0]       rem_r, rem_nxt;
  cp_t              q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r, rd_r;
  logic [QCNT_W-1:0] cnt_r;
  logic             acc, emit, pop;
  cp_t              emit_cp;

  assign full = (cnt_r == QCNT_W'(QDEPTH));
  assign acc  = push && !full;
  assign head.valid = (cnt_r != '0);
  assign head.cp    = q_r[rd_r];
  assign pop  = take && head.valid;

  always_comb begin
    part_nxt = part_r;
    rem_nxt  = rem_r;
    emit     = 1'b0;
    emit_cp  = part_r;
    if (text_byte[7] == 1'b0) begin
      part_nxt = '0;
      rem_nxt  = '0;
      emit     = 1'b1;
      emit_cp  = cp_t'(text_byte);
    end else if (text_byte[6] == 1'b0) begin
      if (rem_r != '0) begin
        emit_cp = {part_r[CP_W-7:0], text_byte[5:0]};
        part_nxt = emit_cp;
        rem_nxt  = rem_r - 2'd1;
        if (rem_r == 2'd1) begin
          emit     = 1'b1;
          part_nxt = '0;
        end
      end
    end else if (text_byte[5] == 1'b0) begin
      part_nxt = cp_t'(text_byte[4:0]);
      rem_nxt  = 2'd1;
    end else if (text_byte[4] == 1'b0) begin
      part_nxt = cp_t'(text_byte[3:0]);
      rem_nxt  = 2'd2;
    end else if (text_byte[3] == 1'b0) begin
      part_nxt = cp_t'(text_byte[2:0]);
      rem_nxt  = 2'd3;
    end else begin
      part_nxt = '0;
      rem_nxt  = '0;
    end
    if (end_of_text) begin
      part_nxt = '0;
      rem_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      part_r <= '0;
      rem_r  <= '0;
      wr_r   <= '0;
      rd_r   <= '0;
      cnt_r  <= '0;
    end else begin
      if (acc) begin
        part_r <= part_nxt;
        rem_r  <= rem_nxt;
      end
      if (acc && emit) begin
        wr_r <= (wr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= (rd_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      cnt_r <= cnt_r + QCNT_W'(acc && emit) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (acc && emit) begin
      q_r[wr_r] <= emit_cp;
    end
  end

`ifndef SYNTHESIS
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    acc && end_of_text |=> rem_r == '0 && part_r == '0)
    else $error("end of text left partial state");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("code point queue overflow");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == '0 && !(acc && emit) |=> cnt_r == '0)
    else $error("code point queue count moved with nothing stored");
`endif

endmodule

@@ design/u2g_back.sv @@
// glyph lookup and result queue
module u2g_back import u2g_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cp_item_t   head,
  output logic       take,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] glyph_code
);

  logic [7:0]        q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r, rd_r;
  logic [QCNT_W-1:0] cnt_r;
  lookup_t           lk;
  logic              deq, enq;

  assign empty = (cnt_r == '0);
  assign deq   = pop && !empty;
  assign glyph_code = q_r[rd_r];
  assign take  = head.valid && ((cnt_r != QCNT_W'(QDEPTH)) || deq);
  assign lk    = glyph_lookup(head.cp);
  assign enq   = take && lk.hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (enq) begin
        wr_r <= (wr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (deq) begin
        rd_r <= (rd_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      cnt_r <= cnt_r + QCNT_W'(enq) - QCNT_W'(deq);
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      q_r[wr_r] <= lk.glyph;
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("result queue overflow");
  a_ascii_hit: assert property (@(posedge clk) disable iff (!rst_n)
    head.valid && head.cp < ASCII_LIMIT |-> lk.hit && lk.glyph == head.cp[7:0])
    else $error("ascii code point not passed through");
  a_take_room: assert property (@(posedge clk) disable iff (!rst_n)
    enq && !deq |-> cnt_r != QCNT_W'(QDEPTH))
    else $error("result written into full queue");
`endif

endmodule

@@ design/utf8_to_glyph_byte_converter.sv @@
// top level of the utf-8 to glyph byte converter
// takes one utf-8 byte per cycle on the in_ queue port while full is low and
// gives zero or one glyph byte per input byte on the out_ queue port. the
// sustained rate is one byte per cycle while out_ is popped every cycle; a
// byte that completes a code point goes into the code point queue register and,
// once the result queue has room, into the result queue register for popping.
// ascii passes unchanged, other code points are matched against a fixed
// 240-entry glyph table and dropped when unmapped. stray continuation bytes
// and invalid lead bytes are dropped, a new lead or ascii byte abandons an
// open sequence, and in_end_of_text clears partial state.
module utf8_to_glyph_byte_converter import u2g_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_text_byte,
  input  logic       in_end_of_text,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_glyph_code
);

  // decoded code point handed from front to back
  cp_item_t cp_head;
  logic     cp_take;

  // front: utf-8 state machine and code point queue
  u2g_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .text_byte   (in_text_byte),
    .end_of_text (in_end_of_text),
    .full        (full),
    .head        (cp_head),
    .take        (cp_take)
  );

  // back: table match and result queue
  u2g_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (cp_head),
    .take       (cp_take),
    .empty      (empty),
    .pop        (pop),
    .glyph_code (out_glyph_code)
  );

endmodule

@@ verif/utf8_to_glyph_byte_converter_tb.sv @@
// self-checking testbench for the utf-8 to glyph byte converter
`timescale 1ns / 1ps

module utf8_to_glyph_byte_converter_tb;
  import u2g_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int RANDOM_ITEMS   = 800;

  // glyph code table, in slot order; glyph byte is 0x10 plus the slot index
  localparam logic [20:0] GLYPH_CP [240] = '{
    21'h025ae, 21'h025a0, 21'h025a1, 21'h02059, 21'h02058, 21'h02016, 21'h025c0, 21'h025b6,
    21'h0300c, 21'h0300d, 21'h000a5, 21'h02022, 21'h03001, 21'h03002, 21'h0309b, 21'h0309c,
    21'h00020, 21'h00021, 21'h00022, 21'h00023, 21'h00024, 21'h00025, 21'h00026, 21'h00027,
    21'h00028, 21'h00029, 21'h0002a, 21'h0002b, 21'h0002c, 21'h0002d, 21'h0002e, 21'h0002f,
    21'h00030, 21'h00031, 21'h00032, 21'h00033, 21'h00034, 21'h00035, 21'h00036, 21'h00037,
    21'h00038, 21'h00039, 21'h0003a, 21'h0003b, 21'h0003c, 21'h0003d, 21'h0003e, 21'h0003f,
    21'h00040, 21'h1d622, 21'h1d623, 21'h1d624, 21'h1d625, 21'h1d626, 21'h1d627, 21'h1d628,
    21'h1d629, 21'h1d62a, 21'h1d62b, 21'h1d62c, 21'h1d62d, 21'h1d62e, 21'h1d62f, 21'h1d630,
    21'h1d631, 21'h1d632, 21'h1d633, 21'h1d634, 21'h1d635, 21'h1d636, 21'h1d637, 21'h1d638,
    21'h1d639, 21'h1d63a, 21'h1d63b, 21'h0005b, 21'h0005c, 21'h0005d, 21'h0005e, 21'h0005f,
    21'h00060, 21'h00061, 21'h00062, 21'h00063, 21'h00064, 21'h00065, 21'h00066, 21'h00067,
    21'h00068, 21'h00069, 21'h0006a, 21'h0006b, 21'h0006c, 21'h0006d, 21'h0006e, 21'h0006f,
    21'h00070, 21'h00071, 21'h00072, 21'h00073, 21'h00074, 21'h00075, 21'h00076, 21'h00077,
    21'h00078, 21'h00079, 21'h0007a, 21'h0007b, 21'h0007c, 21'h0007d, 21'h0007e, 21'h025cb,
    21'h02588, 21'h02592, 21'h1f431, 21'h02b07, 21'h02591, 21'h0273d, 21'h025cf, 21'h02665,
    21'h02609, 21'h0c6c3, 21'h02302, 21'h02b05, 21'h1f610, 21'h0266a, 21'h1f17e, 21'h025c6,
    21'h02026, 21'h027a1, 21'h02605, 21'h029d7, 21'h02b06, 21'h002c7, 21'h02227, 21'h0274e,
    21'h025a4, 21'h025a5, 21'h03042, 21'h03044, 21'h03046, 21'h03048, 21'h0304a, 21'h0304b,
    21'h0304d, 21'h0304f, 21'h03051, 21'h03053, 21'h03055, 21'h03057, 21'h03059, 21'h0305b,
    21'h0305d, 21'h0305f, 21'h03061, 21'h03064, 21'h03066, 21'h03068, 21'h0306a, 21'h0306b,
    21'h0306c, 21'h0306d, 21'h0306e, 21'h0306f, 21'h03072, 21'h03075, 21'h03078, 21'h0307b,
    21'h0307e, 21'h0307f, 21'h03080, 21'h03081, 21'h03082, 21'h03084, 21'h03086, 21'h03088,
    21'h03089, 21'h0308a, 21'h0308b, 21'h0308c, 21'h0308d, 21'h0308f, 21'h03092, 21'h03093,
    21'h03063, 21'h03083, 21'h03085, 21'h03087, 21'h030a2, 21'h030a4, 21'h030a6, 21'h030a8,
    21'h030aa, 21'h030ab, 21'h030ad, 21'h030af, 21'h030b1, 21'h030b3, 21'h030b5, 21'h030b7,
    21'h030b9, 21'h030bb, 21'h030bd, 21'h030bf, 21'h030c1, 21'h030c4, 21'h030c6, 21'h030c8,
    21'h030ca, 21'h030cb, 21'h030cc, 21'h030cd, 21'h030ce, 21'h030cf, 21'h030d2, 21'h030d5,
    21'h030d8, 21'h030db, 21'h030de, 21'h030df, 21'h030e0, 21'h030e1, 21'h030e2, 21'h030e4,
    21'h030e6, 21'h030e8, 21'h030e9, 21'h030ea, 21'h030eb, 21'h030ec, 21'h030ed, 21'h030ef,
    21'h030f2, 21'h030f3, 21'h030c3, 21'h030e3, 21'h030e5, 21'h030e7, 21'h025dc, 21'h025dd
  };

  // directed row: byte, end flag, and a hand-typed glyph where obvious
  typedef struct {
    logic [7:0] text_byte;
    logic       eot;
    logic       typed;     // 1 when an expected glyph is typed in
    logic [7:0] glyph;
  } text_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] in_text_byte = '0;
  logic       in_end_of_text = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] out_glyph_code;

  // decoder shadow state
  logic [20:0] shadow_cp = '0;
  logic [1:0]  shadow_left = '0;

  logic [7:0] pending_glyphs [$];
  int  mismatches = 0;
  int  glyphs_seen = 0;
  int  bytes_sent = 0;
  int  idle_cycles = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;

  utf8_to_glyph_byte_converter u_top (
    .clk, .rst_n, .push, .full, .in_text_byte, .in_end_of_text,
    .empty, .pop, .out_glyph_code
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // map a finished code point to its glyph, hit=0 when unmapped
  function automatic bit map_codepoint(logic [20:0] cp, output logic [7:0] glyph);
    glyph = '0;
    if (cp < 21'h80) begin
      glyph = cp[7:0];
      return 1'b1;
    end
    for (int i = 0; i < 240; i++) begin
      if (GLYPH_CP[i] == cp) begin
        glyph = 8'h10 + 8'(i);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // advance the shadow decoder by one byte; returns 1 with a glyph when one is due
  function automatic bit decode_byte(logic [7:0] b, logic eot, output logic [7:0] glyph);
    bit hit;
    hit = 1'b0;
    glyph = '0;
    if (b < 8'h80) begin
      shadow_left = '0;
      shadow_cp = '0;
      hit = map_codepoint({13'b0, b}, glyph);
    end else if (b < 8'hc0) begin
      // continuation only counts while a sequence is open
      if (shadow_left != 2'd0) begin
        shadow_cp = {shadow_cp[14:0], b[5:0]};
        shadow_left = shadow_left - 2'd1;
        if (shadow_left == 2'd0) begin
          hit = map_codepoint(shadow_cp, glyph);
          shadow_cp = '0;
        end
      end
    end else if (b < 8'he0) begin
      shadow_cp = {16'b0, b[4:0]};
      shadow_left = 2'd1;
    end else if (b < 8'hf0) begin
      shadow_cp = {17'b0, b[3:0]};
      shadow_left = 2'd2;
    end else if (b < 8'hf8) begin
      shadow_cp = {18'b0, b[2:0]};
      shadow_left = 2'd3;
    end else begin
      // invalid lead drops the byte and any open sequence
      shadow_cp = '0;
      shadow_left = '0;
    end
    if (eot) begin
      shadow_cp = '0;
      shadow_left = '0;
    end
    return hit;
  endfunction

  // one byte transfer, with random sender idling ahead of it; push stays high
  // after the transfer until the next call or wait_drained takes it down
  task automatic send_byte(logic [7:0] b, logic eot, logic typed = 1'b0,
                           logic [7:0] typed_glyph = '0);
    logic [7:0] glyph;
    bit hit;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_text_byte <= b;
    in_end_of_text <= eot;
    @(posedge clk);
    while (full) @(posedge clk);
    hit = decode_byte(b, eot, glyph);
    if (typed && (!hit || glyph != typed_glyph)) begin
      $display("%0t: table row %02h disagrees with decoder: expected %02h, decoder %02h/%0b",
               $time, b, typed_glyph, glyph, hit);
      mismatches++;
    end
    if (hit) pending_glyphs.insert(pending_glyphs.size(), glyph);
    bytes_sent++;
  endtask

  // encode a code point as utf-8 of the given length (1..4)
  task automatic send_codepoint(logic [20:0] cp, int len, logic eot);
    case (len)
      1: send_byte({1'b0, cp[6:0]}, eot);
      2: begin
        send_byte({3'b110, cp[10:6]}, 1'b0);
        send_byte({2'b10, cp[5:0]}, eot);
      end
      3: begin
        send_byte({4'b1110, cp[15:12]}, 1'b0);
        send_byte({2'b10, cp[11:6]}, 1'b0);
        send_byte({2'b10, cp[5:0]}, eot);
      end
      default: begin
        send_byte({5'b11110, cp[20:18]}, 1'b0);
        send_byte({2'b10, cp[17:12]}, 1'b0);
        send_byte({2'b10, cp[11:6]}, 1'b0);
        send_byte({2'b10, cp[5:0]}, eot);
      end
    endcase
  endtask

  // receiver: random stalls on pop, check every glyph transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if (pop && !empty) begin
        glyphs_seen <= glyphs_seen + 1;
        if (pending_glyphs.size() == 0) begin
          $display("%0t: unexpected glyph transfer: expected none, actual %02h",
                   $time, out_glyph_code);
          mismatches <= mismatches + 1;
        end else begin
          if (out_glyph_code !== pending_glyphs[0]) begin
            $display("%0t: glyph_code mismatch: expected %02h, actual %02h",
                     $time, pending_glyphs[0], out_glyph_code);
            mismatches <= mismatches + 1;
          end
          void'(pending_glyphs.pop_front());
        end
      end
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired, %0d glyphs still expected",
                 $time, pending_glyphs.size());
        $display("utf8_to_glyph_byte_converter_tb NOT OK");
        $finish;
      end
    end
  end

  text_row_t directed [] = '{
    '{8'h00, 1'b0, 1'b1, 8'h00},   // lowest ascii
    '{8'h7f, 1'b0, 1'b1, 8'h7f},   // highest ascii
    '{8'h41, 1'b1, 1'b1, 8'h41},   // ascii carrying end flag
    '{8'hc2, 1'b0, 1'b0, 8'h00},   // yen sign, two bytes
    '{8'ha5, 1'b0, 1'b1, 8'h1a},
    '{8'he2, 1'b0, 1'b0, 8'h00},   // first slot, three bytes
    '{8'h96, 1'b0, 1'b0, 8'h00},
    '{8'hae, 1'b0, 1'b1, 8'h10},
    '{8'hf0, 1'b0, 1'b0, 8'h00},   // four byte cat face
    '{8'h9f, 1'b0, 1'b0, 8'h00},
    '{8'h90, 1'b0, 1'b0, 8'h00},
    '{8'hb1, 1'b0, 1'b1, 8'h82},
    '{8'hbf, 1'b0, 1'b0, 8'h00},   // stray continuation
    '{8'hff, 1'b0, 1'b0, 8'h00},   // invalid lead
    '{8'hef, 1'b0, 1'b0, 8'h00},   // variant selector, unmapped
    '{8'hb8, 1'b0, 1'b0, 8'h00},
    '{8'h8f, 1'b0, 1'b0, 8'h00},
    '{8'he2, 1'b0, 1'b0, 8'h00},   // sequence cut by ascii
    '{8'h20, 1'b0, 1'b1, 8'h20},
    '{8'hdf, 1'b0, 1'b0, 8'h00},   // cut by a new lead
    '{8'he2, 1'b0, 1'b0, 8'h00},
    '{8'h97, 1'b0, 1'b0, 8'h00},
    '{8'h9d, 1'b0, 1'b1, 8'hff},   // last slot
    '{8'hc0, 1'b1, 1'b0, 8'h00},   // lead with end flag, then continuation is stray
    '{8'h80, 1'b0, 1'b0, 8'h00}
  };

  // send a whole phase of random text
  task automatic random_text(int n_bytes);
    int sent_at_start;
    int kind;
    logic [20:0] cp;
    sent_at_start = bytes_sent;
    while (bytes_sent - sent_at_start < n_bytes) begin
      kind = $urandom_range(99);
      if (kind < 45) begin
        // well-formed mapped code point, encoded at its natural length
        cp = GLYPH_CP[$urandom_range(239)];
        send_codepoint(cp, cp < 21'h80 ? 1 : cp < 21'h800 ? 2 : cp < 21'h10000 ? 3 : 4,
                       $urandom_range(9) == 0);
      end else if (kind < 60) begin
        send_codepoint({13'b0, 8'($urandom_range(127))}, 1, $urandom_range(9) == 0);
      end else if (kind < 75) begin
        // random code point at a random length, overlong forms included
        cp = 21'($urandom);
        send_codepoint(cp, $urandom_range(1, 4), $urandom_range(7) == 0);
      end else begin
        // raw noise and broken sequences
        send_byte(8'($urandom), $urandom_range(7) == 0);
      end
    end
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (pending_glyphs.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 23;
    recv_idle_pct = 79;
    foreach (directed[i])
      send_byte(directed[i].text_byte, directed[i].eot, directed[i].typed,
                directed[i].glyph);
    // hold the sender until every glyph has come out
    wait_drained();
    random_text(RANDOM_ITEMS / 3);

    send_idle_pct = 79;
    recv_idle_pct = 23;
    random_text(RANDOM_ITEMS / 3);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_text(RANDOM_ITEMS / 3);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d text bytes (directed, well-formed, overlong and noise), checked %0d glyphs",
             bytes_sent, glyphs_seen);
    if (mismatches == 0) begin
      $display("utf8_to_glyph_byte_converter_tb OK");
    end else begin
      $display("utf8_to_glyph_byte_converter_tb NOT OK");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/u2g_pkg.sv
design/u2g_front.sv
design/u2g_back.sv
design/utf8_to_glyph_byte_converter.sv
verif/utf8_to_glyph_byte_converter_tb.sv
